@@ sv/sid_pkg.sv @@
// shared types and constants for the signed 32-bit divider
`timescale 1ns / 1ps
package sid_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned STEP_CNT_W = 5;

	localparam logic [WORD_W-1:0] MOST_NEG  = 32'h8000_0000;
	localparam logic [WORD_W-1:0] MOST_POS  = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = 5'd31;

	// classified division word handed from front to back
	typedef struct packed {
		logic [WORD_W-1:0] mag_a;
		logic [WORD_W-1:0] mag_b;
		logic              neg;
		logic              sat;
		logic              dz;
	} sid_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} sid_state_t;

endpackage

@@ sv/sid_front.sv @@
// front end: takes operands and classifies them into a division word
`timescale 1ns / 1ps
module sid_front (
	input  logic signed [31:0] dividend,
	input  logic signed [31:0] divisor,
	output sid_pkg::sid_cmd_t  cmd
);
	import sid_pkg::*;

	logic [WORD_W-1:0] a_u;
	logic [WORD_W-1:0] b_u;

	assign a_u = dividend;
	assign b_u = divisor;

	always_comb begin
		cmd.dz    = (b_u == '0);
		cmd.sat   = (a_u == MOST_NEG) && (b_u == MINUS_ONE);
		cmd.neg   = a_u[WORD_W-1] ^ b_u[WORD_W-1];
		cmd.mag_a = a_u[WORD_W-1] ? (WORD_W'(0) - a_u) : a_u;
		cmd.mag_b = b_u[WORD_W-1] ? (WORD_W'(0) - b_u) : b_u;
	end

endmodule

@@ sv/sid_queue.sv @@
// short word queue between front and back
`timescale 1ns / 1ps
module sid_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sid_pkg::sid_cmd_t push_cmd,
	input  logic              pop,
	output sid_pkg::sid_cmd_t head_cmd,
	output logic              full,
	output logic              empty
);
	import sid_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sid_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

@@ sv/sid_back.sv @@
// back end: restoring shift-subtract divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sid_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sid_pkg::sid_cmd_t head_cmd,
	output logic              pop,
	output logic              done,
	output logic signed [31:0] quotient,
	output logic              saturated,
	output logic              divide_by_zero
);
	import sid_pkg::*;

	sid_state_t            state_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [WORD_W-1:0]     rem_q;
	logic [WORD_W-1:0]     qsh_q;
	logic [WORD_W-1:0]     div_q;
	logic                  neg_q;
	logic                  done_q;
	logic [WORD_W-1:0]     quot_q;
	logic                  sat_q;
	logic                  dz_q;

	logic [WORD_W:0]   trial;
	logic              ge;
	logic [WORD_W-1:0] rem_nxt;

	assign pop   = (state_q == ST_IDLE) && !q_empty;
	assign trial = {rem_q, qsh_q[WORD_W-1]} - {1'b0, div_q};
	assign ge    = !trial[WORD_W];
	assign rem_nxt = ge ? trial[WORD_W-1:0] : {rem_q[WORD_W-2:0], qsh_q[WORD_W-1]};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q <= '0;
				qsh_q <= head_cmd.mag_a;
				div_q <= head_cmd.mag_b;
				neg_q <= head_cmd.neg;
			end
			ST_RUN: begin
				rem_q <= rem_nxt;
				qsh_q <= {qsh_q[WORD_W-2:0], ge};
			end
			default: begin
			end
		endcase
		if (pop && (head_cmd.dz || head_cmd.sat)) begin
			quot_q <= head_cmd.dz ? '0 : MOST_POS;
			sat_q  <= head_cmd.sat && !head_cmd.dz;
			dz_q   <= head_cmd.dz;
		end else if (state_q == ST_FIN) begin
			quot_q <= neg_q ? (WORD_W'(0) - qsh_q) : qsh_q;
			sat_q  <= 1'b0;
			dz_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (pop) begin
						if (head_cmd.dz || head_cmd.sat) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign quotient       = quot_q;
	assign saturated      = sat_q;
	assign divide_by_zero = dz_q;

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && sat_q) |-> (quot_q == MOST_POS))
		else $error("saturated word without clamped quotient");

	a_dz_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dz_q) |-> ((quot_q == '0) && !sat_q))
		else $error("divide by zero word with nonzero quotient");

endmodule

@@ sv/signed_int32_divider_unit.sv @@
// top level of the signed 32-bit truncating, saturating divider
//
// channel   direction  handshake              ports
// command   in         start & !busy          dividend, divisor
// result    out        done, one-cycle pulse  quotient, saturated, divide_by_zero
//
// a normal division in the back end loads the word, runs one shift-subtract step per quotient bit,
// then fixes the sign; a zero divisor or the overflow case is answered straight from the load
// the back end takes no new word until it has finished the last; it has a single bit-per-cycle subtractor
// busy rises only when the command queue is full; the front keeps taking words while the
// back divides
// results cannot be held off; done lasts exactly one cycle
// reset is asynchronous and clears the queue and the back-end state machine
`timescale 1ns / 1ps
module signed_int32_divider_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] dividend,
	input  logic signed [31:0] divisor,
	output logic               done,
	output logic signed [31:0] quotient,
	output logic               saturated,
	output logic               divide_by_zero
);
	import sid_pkg::*;

	sid_cmd_t front_cmd;
	sid_cmd_t head_cmd;
	logic     q_full;
	logic     q_empty;
	logic     pop;
	logic     push;

	assign busy = q_full;
	assign push = start && !q_full;

	sid_front u_front (
		.dividend (dividend),
		.divisor  (divisor),
		.cmd      (front_cmd)
	);

	sid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	sid_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.done           (done),
		.quotient       (quotient),
		.saturated      (saturated),
		.divide_by_zero (divide_by_zero)
	);

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the signed 32-bit truncating, saturating divider
`timescale 1ns / 1ps
module testbench;
	import sid_pkg::*;

	localparam int RANDOM_WORDS = 1900;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;
	localparam int TAB_ROWS     = 24;

	typedef struct packed {
		logic [31:0] quotient;
		logic        sat;
		logic        dz;
	} quo_word_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        known;
		quo_word_t   res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [31:0] dividend = '0;
	logic signed [31:0] divisor = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] quotient;
	logic               saturated;
	logic               divide_by_zero;

	logic      row_known = 1'b0;
	quo_word_t row_typed = '0;
	logic      no_gaps = 1'b0;

	quo_word_t quo_expect_q[$];
	int        n_fail = 0;
	int        stall_cnt = 0;

	// typed results only where they are obvious; the rest go through the predictor
	stim_row_t stim_tab [TAB_ROWS] = '{
		'{32'd0,        32'd0,        1'b1, '{32'd0,         1'b0, 1'b1}},
		'{MOST_NEG,     32'd0,        1'b1, '{32'd0,         1'b0, 1'b1}},
		'{MOST_POS,     32'd0,        1'b1, '{32'd0,         1'b0, 1'b1}},
		'{MINUS_ONE,    32'd0,        1'b1, '{32'd0,         1'b0, 1'b1}},
		'{MOST_NEG,     MINUS_ONE,    1'b1, '{MOST_POS,      1'b1, 1'b0}},
		'{MOST_NEG,     32'd1,        1'b1, '{MOST_NEG,      1'b0, 1'b0}},
		'{MOST_POS,     32'd1,        1'b1, '{MOST_POS,      1'b0, 1'b0}},
		'{MOST_POS,     MINUS_ONE,    1'b1, '{32'h8000_0001, 1'b0, 1'b0}},
		'{MOST_NEG,     MOST_NEG,     1'b1, '{32'd1,         1'b0, 1'b0}},
		'{MOST_POS,     MOST_POS,     1'b1, '{32'd1,         1'b0, 1'b0}},
		'{MOST_POS,     MOST_NEG,     1'b1, '{32'd0,         1'b0, 1'b0}},
		'{MOST_NEG,     MOST_POS,     1'b1, '{MINUS_ONE,     1'b0, 1'b0}},
		'{MOST_NEG,     32'd2,        1'b1, '{32'hC000_0000, 1'b0, 1'b0}},
		'{MOST_NEG,     32'hFFFF_FFFE, 1'b1, '{32'h4000_0000, 1'b0, 1'b0}},
		'{32'd0,        MINUS_ONE,    1'b1, '{32'd0,         1'b0, 1'b0}},
		'{MINUS_ONE,    MINUS_ONE,    1'b1, '{32'd1,         1'b0, 1'b0}},
		'{32'd7,        32'hFFFF_FFFE, 1'b0, '0},
		'{32'hFFFF_FFF9, 32'd2,       1'b0, '0},
		'{32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, '0},
		'{32'd1,        MOST_NEG,     1'b0, '0},
		'{32'd123456789, 32'd1000,    1'b0, '0},
		'{32'hFFFF_FFFE, 32'd3,       1'b0, '0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
	};

	signed_int32_divider_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.dividend(dividend),
		.divisor(divisor),
		.done(done),
		.quotient(quotient),
		.saturated(saturated),
		.divide_by_zero(divide_by_zero)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic quo_word_t divide_trunc_sat(input logic [31:0] a, input logic [31:0] b);
		quo_word_t   r;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		r = '0;
		if (b == '0) begin
			r.dz = 1'b1;
		end else if (a == MOST_NEG && b == MINUS_ONE) begin
			r.sat = 1'b1;
			r.quotient = MOST_POS;
		end else begin
			ma = a[31] ? 32'd0 - a : a;
			mb = b[31] ? 32'd0 - b : b;
			q = ma / mb;
			r.quotient = (a[31] ^ b[31]) ? 32'd0 - q : q;
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 11))
			0: v = MOST_NEG;
			1: v = MOST_POS;
			2: v = MINUS_ONE;
			3: v = 32'd1;
			4: v = 32'($urandom_range(0, 31)) - 32'd16;
			5: v = 32'd1 << $urandom_range(0, 31);
			6, 7: v = $signed(v) >>> $urandom_range(0, 31);
			8: v = '0;
			default: ;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		n_fail++;
	endtask

	task automatic send_word(input logic [31:0] a, input logic [31:0] b, input logic known,
			input quo_word_t typed);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		dividend <= a;
		divisor <= b;
		row_known <= known;
		row_typed <= typed;
		do @(posedge clk); while (busy);
	endtask

	// result check first, then the word taken at this edge
	always @(posedge clk) begin : result_mon
		quo_word_t want;
		if (done) begin
			if (quo_expect_q.size() == 0) begin
				report_mismatch($sformatf("result %h with no division pending", quotient));
			end else begin
				want = quo_expect_q.pop_front();
				if (quotient !== want.quotient)
					report_mismatch($sformatf("quotient %h, want %h", quotient, want.quotient));
				if (saturated !== want.sat)
					report_mismatch($sformatf("saturated %b, want %b", saturated, want.sat));
				if (divide_by_zero !== want.dz)
					report_mismatch($sformatf("divide_by_zero %b, want %b",
						divide_by_zero, want.dz));
			end
		end
		if (arst_n && start && !busy)
			quo_expect_q.push_back(row_known ? row_typed : divide_trunc_sat(dividend, divisor));
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] a;
		logic [31:0] b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < TAB_ROWS; i++) begin
			if (i % 8 == 0)
				no_gaps = ($urandom_range(0, 1) == 0);
			send_word(stim_tab[i].a, stim_tab[i].b, stim_tab[i].known, stim_tab[i].res);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// every 64 words, pick at random between back-to-back bursts and random gaps
			if (i % 64 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			a = pick_operand();
			b = ($urandom_range(0, 19) == 0) ? 32'd0 : pick_operand();
			send_word(a, b, 1'b0, '0);
		end
		start <= 1'b0;

		while (quo_expect_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (n_fail == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
